// ----- rtl/cnrc_pkg.sv -----
// ----------------------------------------------------------------------------
// Color nearest reference classifier package
// Shared widths, register indexes, class codes, queue entry and reference set.
// ----------------------------------------------------------------------------
package cnrc_pkg;

   localparam int MAX_SAMPLES = 64;
   localparam int ADC_BITS    = 10;
   localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
   localparam int SEEN_W      = $clog2(MAX_SAMPLES);
   localparam int SUM_W       = ADC_BITS + SEEN_W;
   localparam int STEP_W      = $clog2(SUM_W);
   localparam int TOTAL_W     = 12;
   localparam int DIST_W      = 12;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 12;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 32;

   localparam logic [CNT_W-1:0]     SAMPLE_COUNT_RESET = CNT_W'(10);
   localparam logic [TOTAL_W:0]     EMPTY_MARGIN       = (TOTAL_W+1)'(100);
   localparam logic [DIST_W-1:0]    UNCERTAIN_MARGIN   = DIST_W'(50);
   localparam logic [STEP_W-1:0]    LAST_STEP          = STEP_W'(SUM_W - 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SAMPLE_COUNT = 3'd0,
      REG_EMPTY_TOTAL  = 3'd1,
      REG_RED_REF_R    = 3'd2,
      REG_RED_REF_G    = 3'd3,
      REG_RED_REF_B    = 3'd4,
      REG_GREEN_REF_R  = 3'd5,
      REG_GREEN_REF_G  = 3'd6,
      REG_GREEN_REF_B  = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      CLASS_EMPTY     = 2'd0,
      CLASS_UNCERTAIN = 2'd1,
      CLASS_RED       = 2'd2,
      CLASS_GREEN     = 2'd3
   } color_class_type;

   typedef enum logic [1:0] {
      PHASE_RED   = 2'd0,
      PHASE_GREEN = 2'd1,
      PHASE_BLUE  = 2'd2,
      PHASE_SPARE = 2'd3
   } phase_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] taken;
   } chan_entry_type;

   typedef struct packed {
      logic [TOTAL_W-1:0]  empty_total;
      logic [ADC_BITS-1:0] red_r;
      logic [ADC_BITS-1:0] red_g;
      logic [ADC_BITS-1:0] red_b;
      logic [ADC_BITS-1:0] green_r;
      logic [ADC_BITS-1:0] green_g;
      logic [ADC_BITS-1:0] green_b;
   } ref_set_type;

   function automatic logic [ADC_BITS-1:0] absdiff_avg(input logic [ADC_BITS-1:0] a,
                                                       input logic [ADC_BITS-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   function automatic logic [DIST_W-1:0] absdiff_dist(input logic [DIST_W-1:0] a,
                                                      input logic [DIST_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

// ----- rtl/color_nearest_reference_classifier_top.sv -----
// Path from the last blue sample to rsp_tvalid with the divider idle: queue pop,
//   bit-serial divide, distance state, then class and output register.
// Throughput: one sample per cycle while the two-entry channel queue has room;
//   each finished channel holds the divider, a blue one also through distance and output stall.
// Reset: synchronous, active high; CSRs return to sample_count 10, references 0.
// ----------------------------------------------------------------------------
// Color nearest reference classifier
// Averages red, green and blue lit sensor samples and classifies the object by
// L1 distance to red and green reference signatures.
// ----------------------------------------------------------------------------
module color_nearest_reference_classifier_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [cnrc_pkg::REQ_DATA_W-1:0]     req_tdata,  // sample[9:0], zero pad
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // color_class[1:0], avg_red[11:2], avg_green[21:12], avg_blue[31:22]
   output logic [cnrc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cnrc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cnrc_pkg::CSR_DATA_W-1:0]     csr_data
);

   logic [cnrc_pkg::CNT_W-1:0] sample_count_ff;
   cnrc_pkg::ref_set_type      refs_ff;
   logic                       queue_full;
   logic                       queue_empty;
   logic                       push;
   logic                       pop;
   cnrc_pkg::chan_entry_type   push_entry;
   cnrc_pkg::chan_entry_type   pop_entry;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= cnrc_pkg::SAMPLE_COUNT_RESET;
         refs_ff         <= '0;
      end else if (csr_valid && csr_ready) begin
         case (cnrc_pkg::reg_index_type'(csr_index))
            cnrc_pkg::REG_SAMPLE_COUNT: sample_count_ff <= csr_data[cnrc_pkg::CNT_W-1:0];
            cnrc_pkg::REG_EMPTY_TOTAL:  refs_ff.empty_total <= csr_data;
            cnrc_pkg::REG_RED_REF_R:    refs_ff.red_r <= csr_data[cnrc_pkg::ADC_BITS-1:0];
            cnrc_pkg::REG_RED_REF_G:    refs_ff.red_g <= csr_data[cnrc_pkg::ADC_BITS-1:0];
            cnrc_pkg::REG_RED_REF_B:    refs_ff.red_b <= csr_data[cnrc_pkg::ADC_BITS-1:0];
            cnrc_pkg::REG_GREEN_REF_R:  refs_ff.green_r <= csr_data[cnrc_pkg::ADC_BITS-1:0];
            cnrc_pkg::REG_GREEN_REF_G:  refs_ff.green_g <= csr_data[cnrc_pkg::ADC_BITS-1:0];
            cnrc_pkg::REG_GREEN_REF_B:  refs_ff.green_b <= csr_data[cnrc_pkg::ADC_BITS-1:0];
            default: ;
         endcase
      end
   end

   cnrc_accum u_accum (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .sample       (req_tdata[cnrc_pkg::ADC_BITS-1:0]),
      .sample_count (sample_count_ff),
      .queue_full   (queue_full),
      .push         (push),
      .push_entry   (push_entry)
   );

   cnrc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .empty      (queue_empty)
   );

   cnrc_classify u_classify (
      .clock       (clock),
      .reset       (reset),
      .refs        (refs_ff),
      .queue_empty (queue_empty),
      .queue_entry (pop_entry),
      .queue_pop   (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

// ----- rtl/cnrc_accum.sv -----
// ----------------------------------------------------------------------------
// Channel accumulator
// Accepts samples, sums the current channel and pushes the finished channel
// sum and sample count into the queue.
// ----------------------------------------------------------------------------
module cnrc_accum (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [cnrc_pkg::ADC_BITS-1:0] sample,
   input  logic [cnrc_pkg::CNT_W-1:0]    sample_count,
   input  logic                          queue_full,
   output logic                          push,
   output cnrc_pkg::chan_entry_type      push_entry
);

   logic [cnrc_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic [cnrc_pkg::SEEN_W-1:0] seen_ff, seen_in;
   logic [cnrc_pkg::CNT_W-1:0]  limit;
   logic [cnrc_pkg::CNT_W-1:0]  taken;
   logic [cnrc_pkg::SUM_W-1:0]  sum_next;
   logic                        accept;
   logic                        chan_end;

   always_comb begin
      if (sample_count == '0) begin
         limit = cnrc_pkg::CNT_W'(1);
      end else if (sample_count > cnrc_pkg::CNT_W'(cnrc_pkg::MAX_SAMPLES)) begin
         limit = cnrc_pkg::CNT_W'(cnrc_pkg::MAX_SAMPLES);
      end else begin
         limit = sample_count;
      end
   end

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign taken      = cnrc_pkg::CNT_W'(seen_ff) + cnrc_pkg::CNT_W'(1);
   assign sum_next   = sum_ff + cnrc_pkg::SUM_W'(sample);
   assign chan_end   = (taken >= limit);

   assign push             = accept && chan_end;
   assign push_entry.sum   = sum_next;
   assign push_entry.taken = taken;

   always_comb begin
      sum_in  = sum_ff;
      seen_in = seen_ff;
      if (accept) begin
         if (chan_end) begin
            sum_in  = '0;
            seen_in = '0;
         end else begin
            sum_in  = sum_next;
            seen_in = taken[cnrc_pkg::SEEN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         seen_ff <= '0;
      end else begin
         sum_ff  <= sum_in;
         seen_ff <= seen_in;
      end
   end

endmodule

// ----- rtl/cnrc_fifo.sv -----
// ----------------------------------------------------------------------------
// Channel queue
// Two-entry queue of finished channel sums between accumulator and divider.
// ----------------------------------------------------------------------------
module cnrc_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  cnrc_pkg::chan_entry_type push_entry,
   output logic                     full,
   input  logic                     pop,
   output cnrc_pkg::chan_entry_type pop_entry,
   output logic                     empty
);

   cnrc_pkg::chan_entry_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign full      = (count_ff == 2'd2);
   assign empty     = (count_ff == 2'd0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign pop_entry = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/cnrc_classify.sv -----
// ----------------------------------------------------------------------------
// Divider and classifier
// Divides each channel sum by its sample count one bit per cycle, keeps the
// channel averages and, after blue, forms the class and holds the result.
// ----------------------------------------------------------------------------
module cnrc_classify (
   input  logic                                clock,
   input  logic                                reset,
   input  cnrc_pkg::ref_set_type               refs,
   input  logic                                queue_empty,
   input  cnrc_pkg::chan_entry_type            queue_entry,
   output logic                                queue_pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [cnrc_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_DIST = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   localparam int AW = cnrc_pkg::ADC_BITS;
   localparam int DW = cnrc_pkg::DIST_W;

   state_type                        state_ff, state_in;
   cnrc_pkg::phase_type              phase_ff, phase_in;
   logic [cnrc_pkg::SUM_W-1:0]       quo_ff, quo_in;
   logic [cnrc_pkg::CNT_W-1:0]       rem_ff, rem_in;
   logic [cnrc_pkg::CNT_W-1:0]       div_ff, div_in;
   logic [cnrc_pkg::STEP_W-1:0]      step_ff, step_in;
   logic [AW-1:0]                    red_ff, red_in;
   logic [AW-1:0]                    green_ff, green_in;
   logic [AW-1:0]                    blue_ff, blue_in;
   logic                             empty_ff, empty_in;
   logic [DW-1:0]                    dred_ff, dred_in;
   logic [DW-1:0]                    dgrn_ff, dgrn_in;
   logic                             out_valid_ff, out_valid_in;
   logic [cnrc_pkg::RSP_DATA_W-1:0]  out_data_ff, out_data_in;

   logic [cnrc_pkg::CNT_W:0]         shifted;
   logic [cnrc_pkg::CNT_W:0]         trial;
   logic                             fits;
   logic [cnrc_pkg::SUM_W-1:0]       quo_step;
   logic [AW-1:0]                    avg;
   logic [cnrc_pkg::TOTAL_W:0]       total;
   logic                             out_free;
   cnrc_pkg::color_class_type        cls;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign queue_pop  = (state_ff == ST_IDLE) && !queue_empty;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   assign shifted  = {rem_ff, quo_ff[cnrc_pkg::SUM_W-1]};
   assign trial    = shifted - {1'b0, div_ff};
   assign fits     = (shifted >= {1'b0, div_ff});
   assign quo_step = {quo_ff[cnrc_pkg::SUM_W-2:0], fits};
   assign avg      = quo_step[AW-1:0];

   assign total = (cnrc_pkg::TOTAL_W+1)'(red_ff) + (cnrc_pkg::TOTAL_W+1)'(green_ff)
                + (cnrc_pkg::TOTAL_W+1)'(blue_ff);

   always_comb begin
      if (empty_ff) begin
         cls = cnrc_pkg::CLASS_EMPTY;
      end else if (cnrc_pkg::absdiff_dist(dred_ff, dgrn_ff) < cnrc_pkg::UNCERTAIN_MARGIN) begin
         cls = cnrc_pkg::CLASS_UNCERTAIN;
      end else if (dred_ff < dgrn_ff) begin
         cls = cnrc_pkg::CLASS_RED;
      end else begin
         cls = cnrc_pkg::CLASS_GREEN;
      end
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      step_in      = step_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      empty_in     = empty_ff;
      dred_in      = dred_ff;
      dgrn_in      = dgrn_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;

      if (state_ff == ST_DIV) begin
         quo_in = quo_step;
         if (fits) begin
            rem_in = trial[cnrc_pkg::CNT_W-1:0];
         end else begin
            rem_in = shifted[cnrc_pkg::CNT_W-1:0];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               quo_in   = queue_entry.sum;
               div_in   = queue_entry.taken;
               rem_in   = '0;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            step_in = step_ff + cnrc_pkg::STEP_W'(1);
            if (step_ff == cnrc_pkg::LAST_STEP) begin
               case (phase_ff)
                  cnrc_pkg::PHASE_RED: begin
                     red_in   = avg;
                     phase_in = cnrc_pkg::PHASE_GREEN;
                     state_in = ST_IDLE;
                  end
                  cnrc_pkg::PHASE_GREEN: begin
                     green_in = avg;
                     phase_in = cnrc_pkg::PHASE_BLUE;
                     state_in = ST_IDLE;
                  end
                  default: begin
                     blue_in  = avg;
                     phase_in = cnrc_pkg::PHASE_RED;
                     state_in = ST_DIST;
                  end
               endcase
            end
         end
         ST_DIST: begin
            empty_in = total < ((cnrc_pkg::TOTAL_W+1)'(refs.empty_total)
                              + cnrc_pkg::EMPTY_MARGIN);
            dred_in  = DW'(cnrc_pkg::absdiff_avg(red_ff, refs.red_r))
                     + DW'(cnrc_pkg::absdiff_avg(green_ff, refs.red_g))
                     + DW'(cnrc_pkg::absdiff_avg(blue_ff, refs.red_b));
            dgrn_in  = DW'(cnrc_pkg::absdiff_avg(red_ff, refs.green_r))
                     + DW'(cnrc_pkg::absdiff_avg(green_ff, refs.green_g))
                     + DW'(cnrc_pkg::absdiff_avg(blue_ff, refs.green_b));
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_data_in  = {blue_ff, green_ff, red_ff, cls};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      step_ff     <= step_in;
      blue_ff     <= blue_in;
      empty_ff    <= empty_in;
      dred_ff     <= dred_in;
      dgrn_ff     <= dgrn_in;
      out_data_ff <= out_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= cnrc_pkg::PHASE_RED;
         red_ff       <= '0;
         green_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         red_ff       <= red_in;
         green_ff     <= green_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule
